// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds whenever the antecedent holds
`define ASSERT_IMPLIES(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) else $error(msg);

`endif

// ----- rtl/rotc_pkg.sv -----
// types and constants of the rectangle obstacle table check unit
`default_nettype none

package rotc_pkg;

	localparam int MAX_BOXES = 1024;
	localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CW = $clog2(MAX_BOXES + 1);

	localparam logic signed [15:0] MAP_X_MIN_RST = -16'sd25600;
	localparam logic signed [15:0] MAP_X_MAX_RST = 16'sd25600;
	localparam logic signed [15:0] MAP_Y_MIN_RST = -16'sd25600;
	localparam logic signed [15:0] MAP_Y_MAX_RST = 16'sd25600;
	localparam logic [31:0] RANGE_SQ_RST = 32'd262144;

	typedef enum logic [2:0] {
		FN_ADD_KNOWN   = 3'd0,
		FN_ADD_UNKNOWN = 3'd1,
		FN_DETECT      = 3'd2,
		FN_CHECK_KNOWN = 3'd3,
		FN_CHECK_REAL  = 3'd4,
		FN_REVEAL      = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		REG_X_MIN    = 3'd0,
		REG_X_MAX    = 3'd1,
		REG_Y_MIN    = 3'd2,
		REG_Y_MAX    = 3'd3,
		REG_RANGE_SQ = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_RD,
		ST_EX,
		ST_EY,
		ST_EC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               known;
		logic [14:0]        span_y;
		logic [14:0]        span_x;
		logic signed [15:0] bottom;
		logic signed [15:0] left;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	typedef struct packed {
		logic sq_en;
		logic sel_y;
		logic acc_en;
	} eval_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/rectangle_obstacle_table_check_unit.sv -----
// add writes one table entry; query, reveal and detect scan the stored rectangles,
// one table ram read per entry
// throughput: one word at a time, the next word is taken once the result is in the
// output register; detect squares each unknown entry's gaps on the shared multiplier
// reset: asynchronous, clears the fill count, flags and handshakes, map bounds and range
// return to defaults; the table ram needs no clearing pass
`default_nettype none
`include "assert_macros.svh"

module rectangle_obstacle_table_check_unit import rotc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// pos_x, pos_y, rect_x, rect_y, rect_width, rect_height, zero pad
	input  wire logic [95:0] s_axis_tdata,
	// func
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// position_valid, found_new, table_full, zero pad
	output logic [7:0]       m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_data
);

	state_t state_q, state_d;
	func_t func_q, in_func;
	logic signed [15:0] pos_x_q, pos_y_q;
	box_t new_box_q;
	logic [CW-1:0] idx_q, used_count_q;
	logic hit_q, found_q, full_q;
	logic signed [15:0] map_x_min_q, map_x_max_q, map_y_min_q, map_y_max_q;
	logic [31:0] range_q;
	logic m_valid_q;
	logic [2:0] m_data_q;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	box_t ram_wdata, ram_rdata;
	eval_ctl_t ctl;
	logic in_box, below;
	logic idx_inc, set_hit, set_found, set_full, cnt_inc, load_out;
	logic is_query, in_map, pos_valid;
	logic in_fire;

	assign in_func = func_t'(s_axis_tuser);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {5'b00000, m_data_q};

	rotc_ram #(
		.WIDTH(BOX_W),
		.DEPTH(MAX_BOXES)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	rotc_eval u_eval (
		.clk(clk),
		.ctl(ctl),
		.pos_x(pos_x_q),
		.pos_y(pos_y_q),
		.box(ram_rdata),
		.range_sq(range_q),
		.in_box(in_box),
		.below(below)
	);

	always_comb begin
		is_query = (func_q == FN_CHECK_KNOWN) || (func_q == FN_CHECK_REAL);
		in_map = (pos_x_q > map_x_min_q) && (pos_x_q < map_x_max_q) &&
			(pos_y_q > map_y_min_q) && (pos_y_q < map_y_max_q);
		pos_valid = is_query && !hit_q && in_map;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_wdata.known = 1'b1;
		ctl = '0;
		idx_inc = 1'b0;
		set_hit = 1'b0;
		set_found = 1'b0;
		set_full = 1'b0;
		cnt_inc = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					case (in_func)
						FN_ADD_KNOWN, FN_ADD_UNKNOWN: state_d = ST_ADD;
						FN_DETECT, FN_CHECK_KNOWN, FN_CHECK_REAL, FN_REVEAL: state_d = ST_RD;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_ADD: begin
				if (used_count_q == CW'(MAX_BOXES)) begin
					set_full = 1'b1;
				end else begin
					ram_we = 1'b1;
					ram_waddr = used_count_q[AW-1:0];
					ram_wdata = new_box_q;
					cnt_inc = 1'b1;
				end
				state_d = ST_FIN;
			end
			ST_RD: begin
				if (idx_q == used_count_q) begin
					state_d = ST_FIN;
				end else begin
					ram_re = 1'b1;
					state_d = ST_EX;
				end
			end
			ST_EX: begin
				case (func_q)
					FN_DETECT: begin
						if (ram_rdata.known) begin
							idx_inc = 1'b1;
							state_d = ST_RD;
						end else begin
							ctl.sq_en = 1'b1;
							state_d = ST_EY;
						end
					end
					FN_REVEAL: begin
						if (!ram_rdata.known) begin
							ram_we = 1'b1;
							set_found = 1'b1;
						end
						idx_inc = 1'b1;
						state_d = ST_RD;
					end
					default: begin
						if ((ram_rdata.known || func_q == FN_CHECK_REAL) && in_box) begin
							set_hit = 1'b1;
						end
						idx_inc = 1'b1;
						state_d = ST_RD;
					end
				endcase
			end
			ST_EY: begin
				ctl.sq_en = 1'b1;
				ctl.sel_y = 1'b1;
				ctl.acc_en = 1'b1;
				state_d = ST_EC;
			end
			ST_EC: begin
				if (below) begin
					ram_we = 1'b1;
					set_found = 1'b1;
				end
				idx_inc = 1'b1;
				state_d = ST_RD;
			end
			ST_FIN: begin
				if (!m_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// function capture, scan index, control flags, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q <= FN_ADD_KNOWN;
			idx_q <= '0;
			used_count_q <= '0;
			hit_q <= 1'b0;
			found_q <= 1'b0;
			full_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			if (in_fire) begin
				func_q <= in_func;
				idx_q <= '0;
				hit_q <= 1'b0;
				found_q <= 1'b0;
				full_q <= 1'b0;
			end else begin
				if (idx_inc) begin
					idx_q <= idx_q + 1'b1;
				end
				if (set_hit) begin
					hit_q <= 1'b1;
				end
				if (set_found) begin
					found_q <= 1'b1;
				end
				if (set_full) begin
					full_q <= 1'b1;
				end
			end
			if (cnt_inc) begin
				used_count_q <= used_count_q + 1'b1;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
				m_data_q <= {full_q, found_q, pos_valid};
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_x_q <= s_axis_tdata[15:0];
			pos_y_q <= s_axis_tdata[31:16];
			new_box_q.left <= s_axis_tdata[47:32];
			new_box_q.bottom <= s_axis_tdata[63:48];
			new_box_q.span_x <= s_axis_tdata[78:64];
			new_box_q.span_y <= s_axis_tdata[93:79];
			new_box_q.known <= (in_func == FN_ADD_KNOWN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_x_min_q <= MAP_X_MIN_RST;
			map_x_max_q <= MAP_X_MAX_RST;
			map_y_min_q <= MAP_Y_MIN_RST;
			map_y_max_q <= MAP_Y_MAX_RST;
			range_q <= RANGE_SQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_addr))
				REG_X_MIN: map_x_min_q <= cfg_data[15:0];
				REG_X_MAX: map_x_max_q <= cfg_data[15:0];
				REG_Y_MIN: map_y_min_q <= cfg_data[15:0];
				REG_Y_MAX: map_y_max_q <= cfg_data[15:0];
				REG_RANGE_SQ: range_q <= cfg_data;
				default: ;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_count_bound, used_count_q <= CW'(MAX_BOXES), "fill count past table size")
	`ASSERT_ALWAYS(a_scan_bound, idx_q <= used_count_q, "scan index past fill count")
	`ASSERT_IMPLIES(a_ram_port, ram_we, !ram_re, "table read and write in one cycle")
	`ASSERT_IMPLIES(a_found_func, found_q, func_q == FN_DETECT || func_q == FN_REVEAL, "found flag on wrong function")

endmodule

`default_nettype wire

// ----- rtl/rotc_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module rotc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rotc_eval.sv -----
// shared box evaluation unit: edge gap, registered square, sum and compares
`default_nettype none

module rotc_eval import rotc_pkg::*; (
	input  wire logic               clk,
	input  wire eval_ctl_t          ctl,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire box_t               box,
	input  wire logic [31:0]        range_sq,
	output logic                    in_box,
	output logic                    below
);

	logic signed [17:0] px, py, lo_x, hi_x, lo_y, hi_y;
	logic signed [17:0] p_sel, lo_sel, hi_sel, d_lo, d_hi;
	logic [15:0] gap;
	logic [31:0] sq_q, acc_q;
	logic [32:0] dist_sum;

	always_comb begin
		px = {{2{pos_x[15]}}, pos_x};
		py = {{2{pos_y[15]}}, pos_y};
		lo_x = {{2{box.left[15]}}, box.left};
		lo_y = {{2{box.bottom[15]}}, box.bottom};
		hi_x = lo_x + $signed({3'b000, box.span_x});
		hi_y = lo_y + $signed({3'b000, box.span_y});
		in_box = (px > lo_x) && (px < hi_x) && (py > lo_y) && (py < hi_y);

		p_sel = ctl.sel_y ? py : px;
		lo_sel = ctl.sel_y ? lo_y : lo_x;
		hi_sel = ctl.sel_y ? hi_y : hi_x;
		d_lo = lo_sel - p_sel;
		d_hi = p_sel - hi_sel;
		if (d_lo > 18'sd0) begin
			gap = d_lo[15:0];
		end else if (d_hi > 18'sd0) begin
			gap = d_hi[15:0];
		end else begin
			gap = 16'd0;
		end

		dist_sum = {1'b0, acc_q} + {1'b0, sq_q};
		below = dist_sum < {1'b0, range_sq};
	end

	always_ff @(posedge clk) begin
		if (ctl.sq_en) begin
			sq_q <= gap * gap;
		end
		if (ctl.acc_en) begin
			acc_q <= sq_q;
		end
	end

endmodule

`default_nettype wire
